// ===== hdl/tdf_pkg.sv =====
// ----------------------------------------------------------------------------
// tdf_pkg: shared definitions for the trial division factorizer
// Widths, status codes, sequencer ops, conditions and the microprogram.
// ----------------------------------------------------------------------------
package tdf_pkg;

   // magnitude datapath width; inputs above 2^MAG_W - 1 saturate
   localparam int MAG_W       = 31;
   localparam int VALUE_W     = 32;
   localparam int PRIME_W     = 31;
   localparam int EXP_W       = 5;
   localparam int STATUS_W    = 2;
   localparam int MAX_RESULTS = 9;
   localparam int N_W         = $clog2(MAX_RESULTS + 1);
   localparam int CNT_W       = $clog2(MAG_W + 1);

   localparam logic [63:0] MAG_MAX = (64'd1 << MAG_W) - 64'd1;
   localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};

   localparam logic [STATUS_W-1:0] STATUS_FACTOR = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNIT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO   = 2'd2;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,  // take a request, load magnitude and sign
      OP_DIV,     // start divider: rem / d
      OP_WAIT,    // hold while divider busy
      OP_SHIFT,   // rem <= quotient, exponent + 1
      OP_EMIT_F,  // stage (d, e) as pending result
      OP_NEXTD,   // next trial divisor, clear exponent
      OP_EMIT_T,  // stage (rem, 1) as pending result
      OP_FIN,     // send pending result marked last
      OP_ZERO,    // send zero status result
      OP_UNIT     // send unit status result
   } op_type;

   typedef enum logic [3:0] {
      C_NONE,
      C_ALWAYS,
      C_REM_ZERO,
      C_REM_ONE,
      C_N_MAX,
      C_D_GT_Q,
      C_R_NZ,
      C_R_Z,
      C_REM_LE1
   } cond_type;

   localparam int PC_W     = 5;
   localparam int PROG_LEN = 17;

   localparam logic [PC_W-1:0] STEP_ACCEPT = 5'd0;
   localparam logic [PC_W-1:0] STEP_TEST_N = 5'd3;
   localparam logic [PC_W-1:0] STEP_SHIFT  = 5'd7;
   localparam logic [PC_W-1:0] STEP_NEXTD  = 5'd11;
   localparam logic [PC_W-1:0] STEP_TAIL   = 5'd12;
   localparam logic [PC_W-1:0] STEP_FIN    = 5'd14;
   localparam logic [PC_W-1:0] STEP_ZERO   = 5'd15;
   localparam logic [PC_W-1:0] STEP_UNIT   = 5'd16;
   localparam logic [PC_W-1:0] STEP_LAST   = 5'd16;

   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } ctrl_word_type;

   localparam ctrl_word_type PROGRAM [PROG_LEN] = '{
      '{OP_ACCEPT, C_NONE,     STEP_ACCEPT},  //  0 wait for request
      '{OP_NOP,    C_REM_ZERO, STEP_ZERO},    //  1
      '{OP_NOP,    C_REM_ONE,  STEP_UNIT},    //  2
      '{OP_NOP,    C_N_MAX,    STEP_FIN},     //  3 outer loop head
      '{OP_DIV,    C_NONE,     STEP_ACCEPT},  //  4
      '{OP_WAIT,   C_D_GT_Q,   STEP_TAIL},    //  5 d*d > rem: done
      '{OP_NOP,    C_R_NZ,     STEP_NEXTD},   //  6 not a factor
      '{OP_SHIFT,  C_NONE,     STEP_ACCEPT},  //  7 inner loop head
      '{OP_DIV,    C_NONE,     STEP_ACCEPT},  //  8
      '{OP_WAIT,   C_R_Z,      STEP_SHIFT},   //  9 divides again
      '{OP_EMIT_F, C_NONE,     STEP_ACCEPT},  // 10
      '{OP_NEXTD,  C_ALWAYS,   STEP_TEST_N},  // 11
      '{OP_NOP,    C_REM_LE1,  STEP_FIN},     // 12 tail cofactor
      '{OP_EMIT_T, C_NONE,     STEP_ACCEPT},  // 13
      '{OP_FIN,    C_ALWAYS,   STEP_ACCEPT},  // 14
      '{OP_ZERO,   C_ALWAYS,   STEP_ACCEPT},  // 15
      '{OP_UNIT,   C_ALWAYS,   STEP_ACCEPT}   // 16
   };

   // low PRIME_W bits of a magnitude, zero padded when MAG_W is narrower
   function automatic logic [PRIME_W-1:0] to_prime(input logic [MAG_W-1:0] x);
      logic [MAG_W+PRIME_W-1:0] t;
      t = {{PRIME_W{1'b0}}, x};
      return t[PRIME_W-1:0];
   endfunction

endpackage

// ===== hdl/trial_division_factorizer_top.sv =====
// ----------------------------------------------------------------------------
// trial_division_factorizer_top: prime factorization by trial division
// Microcoded sequencer over a restoring divider; emits (prime, exponent) runs.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------
//  req     | in  | req_valid / req_ready | req_value (32b signed)
//  rsp     | out | rsp_valid / rsp_ready | is_negative, prime_factor,
//          |     |                       | exponent, status, last
//
//  Each trial division holds the sequencer until the shared divider is done,
//  plus four more steps; the worst case is near 2^15.5 / 2 odd divisors.
//  Reset: synchronous, clears the step counter, divider count and valids.
//  Stalls: a held response blocks only the step that must hand over the next
//  one; division keeps running meanwhile. One request in flight at a time.
//
module trial_division_factorizer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [tdf_pkg::VALUE_W-1:0] req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_is_negative,
   output logic [tdf_pkg::PRIME_W-1:0]      rsp_prime_factor,
   output logic [tdf_pkg::EXP_W-1:0]        rsp_exponent,
   output logic [tdf_pkg::STATUS_W-1:0]     rsp_status,
   output logic                             rsp_last
);

   localparam int MW = tdf_pkg::MAG_W;

   // sequencer
   logic [tdf_pkg::PC_W-1:0] pc_ff, pc_in;
   tdf_pkg::ctrl_word_type   cw;
   logic                     stall, cond_true;

   // datapath
   logic [MW-1:0]              rem_ff, rem_in;
   logic [MW-1:0]              d_ff, d_in;
   logic [tdf_pkg::EXP_W-1:0]  e_ff, e_in;
   logic [tdf_pkg::N_W-1:0]    n_ff, n_in;
   logic                       neg_ff, neg_in;

   // divider
   logic [MW-1:0]              div_q_ff, div_q_in;
   logic [MW-1:0]              div_r_ff, div_r_in;
   logic [tdf_pkg::CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [MW:0]                div_shift;
   logic                       div_ge, div_busy;

   // pending result and output register
   logic                          pend_valid_ff, pend_valid_in;
   logic [tdf_pkg::PRIME_W-1:0]   pend_prime_ff, pend_prime_in;
   logic [tdf_pkg::EXP_W-1:0]     pend_exp_ff, pend_exp_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_neg_ff, rsp_neg_in;
   logic [tdf_pkg::PRIME_W-1:0]   rsp_prime_ff, rsp_prime_in;
   logic [tdf_pkg::EXP_W-1:0]     rsp_exp_ff, rsp_exp_in;
   logic [tdf_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          out_full, push;

   // input magnitude with saturation
   logic [tdf_pkg::VALUE_W-1:0] mag32;
   logic [63:0]                 mag64;
   logic [MW-1:0]               mag_sat;

   always_comb begin
      mag32 = req_value[tdf_pkg::VALUE_W-1] ? (~req_value + 32'd1) : req_value;
      mag64 = {32'd0, mag32};
      if (mag64 > tdf_pkg::MAG_MAX) begin
         mag64 = tdf_pkg::MAG_MAX;
      end
      mag_sat = mag64[MW-1:0];
   end

   // microprogram fetch
   always_comb begin
      cw = tdf_pkg::PROGRAM[pc_ff];
   end

   assign out_full = rsp_valid_ff && !rsp_ready;
   assign div_busy = (div_cnt_ff != '0);

   // per-step stall: missing request, busy divider, or nowhere to put a result
   always_comb begin
      case (cw.op)
         tdf_pkg::OP_ACCEPT: stall = !req_valid;
         tdf_pkg::OP_WAIT:   stall = div_busy;
         tdf_pkg::OP_EMIT_F,
         tdf_pkg::OP_EMIT_T: stall = pend_valid_ff && out_full;
         tdf_pkg::OP_FIN,
         tdf_pkg::OP_ZERO,
         tdf_pkg::OP_UNIT:   stall = out_full;
         default:            stall = 1'b0;
      endcase
   end

   always_comb begin
      case (cw.cond)
         tdf_pkg::C_ALWAYS:   cond_true = 1'b1;
         tdf_pkg::C_REM_ZERO: cond_true = (rem_ff == '0);
         tdf_pkg::C_REM_ONE:  cond_true = (rem_ff == MW'(1));
         tdf_pkg::C_N_MAX:    cond_true = (n_ff == tdf_pkg::N_W'(tdf_pkg::MAX_RESULTS));
         tdf_pkg::C_D_GT_Q:   cond_true = (d_ff > div_q_ff);
         tdf_pkg::C_R_NZ:     cond_true = (div_r_ff != '0);
         tdf_pkg::C_R_Z:      cond_true = (div_r_ff == '0);
         tdf_pkg::C_REM_LE1:  cond_true = (rem_ff < MW'(2));
         default:             cond_true = 1'b0;
      endcase
   end

   always_comb begin
      if (stall) begin
         pc_in = pc_ff;
      end else if (cond_true) begin
         pc_in = cw.target;
      end else if (pc_ff == tdf_pkg::STEP_LAST) begin
         pc_in = tdf_pkg::STEP_ACCEPT;
      end else begin
         pc_in = pc_ff + tdf_pkg::PC_W'(1);
      end
   end

   assign req_ready = (cw.op == tdf_pkg::OP_ACCEPT);

   // restoring divider, one quotient bit per cycle
   always_comb begin
      div_shift = {div_r_ff, div_q_ff[MW-1]};
      div_ge    = (div_shift >= {1'b0, d_ff});
      div_q_in   = div_q_ff;
      div_r_in   = div_r_ff;
      div_cnt_in = div_cnt_ff;
      if (cw.op == tdf_pkg::OP_DIV) begin
         div_q_in   = rem_ff;
         div_r_in   = '0;
         div_cnt_in = tdf_pkg::CNT_W'(MW);
      end else if (div_busy) begin
         div_q_in   = {div_q_ff[MW-2:0], div_ge};
         div_r_in   = div_ge ? MW'(div_shift - {1'b0, d_ff}) : div_shift[MW-1:0];
         div_cnt_in = div_cnt_ff - tdf_pkg::CNT_W'(1);
      end
   end

   // datapath and result staging
   always_comb begin
      rem_in        = rem_ff;
      d_in          = d_ff;
      e_in          = e_ff;
      n_in          = n_ff;
      neg_in        = neg_ff;
      pend_valid_in = pend_valid_ff;
      pend_prime_in = pend_prime_ff;
      pend_exp_in   = pend_exp_ff;
      push          = 1'b0;
      rsp_neg_in    = rsp_neg_ff;
      rsp_prime_in  = rsp_prime_ff;
      rsp_exp_in    = rsp_exp_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (!stall) begin
         case (cw.op)
            tdf_pkg::OP_ACCEPT: begin
               rem_in = mag_sat;
               neg_in = req_value[tdf_pkg::VALUE_W-1];
               d_in   = MW'(2);
               e_in   = '0;
               n_in   = '0;
            end
            tdf_pkg::OP_SHIFT: begin
               rem_in = div_q_ff;
               e_in   = (e_ff == tdf_pkg::EXP_MAX) ? e_ff : e_ff + tdf_pkg::EXP_W'(1);
            end
            tdf_pkg::OP_NEXTD: begin
               d_in = (d_ff == MW'(2)) ? MW'(3) : d_ff + MW'(2);
               e_in = '0;
            end
            tdf_pkg::OP_EMIT_F,
            tdf_pkg::OP_EMIT_T: begin
               // previous pending result is known not to be last
               if (pend_valid_ff) begin
                  push          = 1'b1;
                  rsp_neg_in    = neg_ff;
                  rsp_prime_in  = pend_prime_ff;
                  rsp_exp_in    = pend_exp_ff;
                  rsp_status_in = tdf_pkg::STATUS_FACTOR;
                  rsp_last_in   = 1'b0;
               end
               pend_valid_in = 1'b1;
               n_in          = n_ff + tdf_pkg::N_W'(1);
               if (cw.op == tdf_pkg::OP_EMIT_F) begin
                  pend_prime_in = tdf_pkg::to_prime(d_ff);
                  pend_exp_in   = e_ff;
               end else begin
                  pend_prime_in = tdf_pkg::to_prime(rem_ff);
                  pend_exp_in   = tdf_pkg::EXP_W'(1);
                  rem_in        = MW'(1);
               end
            end
            tdf_pkg::OP_FIN: begin
               push          = 1'b1;
               pend_valid_in = 1'b0;
               rsp_neg_in    = neg_ff;
               rsp_prime_in  = pend_prime_ff;
               rsp_exp_in    = pend_exp_ff;
               rsp_status_in = tdf_pkg::STATUS_FACTOR;
               rsp_last_in   = 1'b1;
            end
            tdf_pkg::OP_ZERO,
            tdf_pkg::OP_UNIT: begin
               push          = 1'b1;
               rsp_neg_in    = (cw.op == tdf_pkg::OP_UNIT) && neg_ff;
               rsp_prime_in  = '0;
               rsp_exp_in    = '0;
               rsp_status_in = (cw.op == tdf_pkg::OP_UNIT) ? tdf_pkg::STATUS_UNIT
                                                           : tdf_pkg::STATUS_ZERO;
               rsp_last_in   = 1'b1;
            end
            default: begin
            end
         endcase
      end
      rsp_valid_in = push || out_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= tdf_pkg::STEP_ACCEPT;
         div_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         div_cnt_ff    <= div_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      d_ff          <= d_in;
      e_ff          <= e_in;
      n_ff          <= n_in;
      neg_ff        <= neg_in;
      div_q_ff      <= div_q_in;
      div_r_ff      <= div_r_in;
      pend_prime_ff <= pend_prime_in;
      pend_exp_ff   <= pend_exp_in;
      rsp_neg_ff    <= rsp_neg_in;
      rsp_prime_ff  <= rsp_prime_in;
      rsp_exp_ff    <= rsp_exp_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_negative  = rsp_neg_ff;
   assign rsp_prime_factor = rsp_prime_ff;
   assign rsp_exponent     = rsp_exp_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

   // a new request never finds a result of the previous one still staged
   a_accept_no_pending: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !pend_valid_ff)
      else $error("request accepted with a staged result");

   // the divider is only restarted once idle
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      (cw.op == tdf_pkg::OP_DIV) |-> !div_busy)
      else $error("divider restarted while busy");

   // a result is never written over one the consumer has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      push |-> !out_full)
      else $error("response register overwritten");

endmodule

// ===== tb/tb_trial_division_factorizer_top.sv =====
// ----------------------------------------------------------------------------
// tb_trial_division_factorizer_top: self-checking bench for the factorizer
// Sends signed integers over the request channel and checks every
// (prime, exponent) result against a behavioral factorization. Random
// gaps and stalls run on both channels.
// ----------------------------------------------------------------------------
module tb_trial_division_factorizer_top;

   // Longest correct quiet stretch is one full-width prime plus response
   // stalls; allow several times that.
   localparam int QUIET_LIMIT = 4_000_000;
   // Every request yields a result, so after the last one only a few
   // sequencer steps can still be in flight.
   localparam int TAIL_CYCLES = 40;
   localparam int MAX_REPORTS = 10;
   localparam int N_RANDOM    = 78;
   localparam int DRAIN_EVERY = 30;

   // one result of a factorization run
   typedef struct packed {
      logic                         is_negative;
      logic [tdf_pkg::PRIME_W-1:0]  prime_factor;
      logic [tdf_pkg::EXP_W-1:0]    exponent;
      logic [tdf_pkg::STATUS_W-1:0] status;
      logic                         last;
   } factor_rsp_type;

   // one request waiting to be sent; drain_first holds it back until the
   // block has returned every result owed so far
   typedef struct {
      logic signed [tdf_pkg::VALUE_W-1:0] value;
      bit                                 drain_first;
   } factor_req_type;

   logic                                clock     = 1'b0;
   logic                                reset     = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [tdf_pkg::VALUE_W-1:0]  req_value = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic                                rsp_is_negative;
   logic [tdf_pkg::PRIME_W-1:0]         rsp_prime_factor;
   logic [tdf_pkg::EXP_W-1:0]           rsp_exponent;
   logic [tdf_pkg::STATUS_W-1:0]        rsp_status;
   logic                                rsp_last;

   factor_req_type  request_queue [$];
   factor_rsp_type  expected_factors [$];
   int              mismatches   = 0;
   int              quiet_cycles = 0;
   logic            timed_out;

   // pacing state for both sides
   int req_idle = 0;
   int req_calm = 0;
   int rsp_hold = 0;
   int rsp_calm = 0;

   int unsigned small_primes [12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};

   // Directed set: zero, units of both signs, tiny primes, a prime square at
   // the loop bound, two close primes, the largest exponent (2^30), the
   // longest run (product of the first nine primes), 2^30 - 1, the largest
   // prime, and -2^31 which saturates to 2^31 - 1.
   int directed_values [$] = '{
      0, 1, -1, 2, -2, 3, 4, 6, -12, 9, 49, 97, 1155, 10403, 1024,
      1073741824, -1073741824, 223092870, -223092870, 1073741823,
      2147483647, int'(32'h8000_0000)
   };

   trial_division_factorizer_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_negative  (rsp_is_negative),
      .rsp_prime_factor (rsp_prime_factor),
      .rsp_exponent     (rsp_exponent),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Gap length: mostly none or short, now and then long, and calm
   // stretches where nothing idles at all.
   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 4) begin
         calm = $urandom_range(6, 20);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic void queue_value(input logic signed [tdf_pkg::VALUE_W-1:0] v,
                                       input bit drain);
      factor_req_type item;
      item.value       = v;
      item.drain_first = drain;
      request_queue.push_back(item);
   endfunction

   // Factor one request value and append its result run to the expected
   // queue. Works on the magnitude, saturated to the datapath width; 2 first,
   // then odd divisors while d*d <= cofactor; a leftover cofactor is prime.
   // Exponent clamp, prime masking and run truncation only bite at widths
   // above 31.
   function automatic void factorize(input logic signed [tdf_pkg::VALUE_W-1:0] value);
      longint unsigned mag, rem, d, e;
      logic            neg;
      factor_rsp_type  run [$];
      factor_rsp_type  r;
      neg = value[tdf_pkg::VALUE_W-1];
      mag = {32'd0, value};
      if (neg) mag = (64'd1 << tdf_pkg::VALUE_W) - mag;
      if (mag > tdf_pkg::MAG_MAX) mag = tdf_pkg::MAG_MAX;

      // zero: status only, sign dropped
      if (mag == 0) begin
         r = '{1'b0, '0, '0, tdf_pkg::STATUS_ZERO, 1'b1};
         expected_factors.push_back(r);
         return;
      end
      // magnitude one: unit status, sign kept
      if (mag == 1) begin
         r = '{neg, '0, '0, tdf_pkg::STATUS_UNIT, 1'b1};
         expected_factors.push_back(r);
         return;
      end

      rem = mag;
      d   = 2;
      while (run.size() < tdf_pkg::MAX_RESULTS && d <= rem / d) begin
         if (rem % d == 0) begin
            e = 0;
            while (rem % d == 0) begin
               rem = rem / d;
               e++;
            end
            r.is_negative  = neg;
            r.prime_factor = d[tdf_pkg::PRIME_W-1:0];
            r.exponent     = (e > tdf_pkg::EXP_MAX) ? tdf_pkg::EXP_MAX
                                                    : e[tdf_pkg::EXP_W-1:0];
            r.status       = tdf_pkg::STATUS_FACTOR;
            r.last         = 1'b0;
            run.push_back(r);
         end
         d = (d == 2) ? 3 : d + 2;
      end
      // leftover cofactor above one is prime
      if (rem > 1 && run.size() < tdf_pkg::MAX_RESULTS) begin
         r = '{neg, rem[tdf_pkg::PRIME_W-1:0], tdf_pkg::EXP_W'(1),
               tdf_pkg::STATUS_FACTOR, 1'b0};
         run.push_back(r);
         rem = 1;
      end
      run[run.size()-1].last = 1'b1;
      foreach (run[k]) expected_factors.push_back(run[k]);
   endfunction

   // Request driver: predicts on acceptance, then idles a random gap before
   // presenting the next queued request. A held request keeps valid and
   // payload steady until the block takes it.
   always @(posedge clock) begin : drive_requests
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            factorize(req_value);
            req_idle = pick_gap(req_calm);
         end
         if (req_valid && !req_ready) begin
            next_valid = 1'b1;
         end else if (req_idle > 0) begin
            req_idle--;
            next_valid = 1'b0;
         end else if (request_queue.size() != 0 &&
                      !(request_queue[0].drain_first && expected_factors.size() != 0)) begin
            req_value <= request_queue[0].value;
            request_queue.pop_front();
            next_valid = 1'b1;
         end else begin
            next_valid = 1'b0;
         end
         req_valid <= next_valid;
      end
   end

   // Result monitor: checks each accepted result against the oldest
   // expectation and drops ready at random.
   always @(posedge clock) begin : check_results
      factor_rsp_type got, want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_is_negative, rsp_prime_factor, rsp_exponent, rsp_status, rsp_last};
            if (expected_factors.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result: neg=%0b prime=%0d exp=%0d status=%0d last=%0b",
                           got.is_negative, got.prime_factor, got.exponent,
                           got.status, got.last);
            end else begin
               want = expected_factors.pop_front();
               if (got.is_negative !== want.is_negative ||
                   got.prime_factor !== want.prime_factor ||
                   got.exponent !== want.exponent ||
                   got.status !== want.status ||
                   got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("result mismatch: expected neg=%0b prime=%0d exp=%0d %s",
                              want.is_negative, want.prime_factor, want.exponent,
                              $sformatf("status=%0d last=%0b", want.status, want.last));
                     $display("                 got      neg=%0b prime=%0d exp=%0d %s",
                              got.is_negative, got.prime_factor, got.exponent,
                              $sformatf("status=%0d last=%0b", got.status, got.last));
                  end
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_hold = pick_gap(rsp_calm);
         end
      end
   end

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles < QUIET_LIMIT)
         quiet_cycles <= quiet_cycles + 1;
   end
   assign timed_out = (quiet_cycles >= QUIET_LIMIT);

   // Stimulus and end of run. Random values mix small magnitudes, products
   // of small primes (deep runs, high bits), shifted values of 1 to 255 (large
   // powers of 2) and a few wider values; the sign is random. Full-width
   // primes take the longest to factor, so only the directed set has them.
   initial begin
      longint unsigned prod, p;
      int unsigned     kind;
      logic signed [tdf_pkg::VALUE_W-1:0] v;
      foreach (directed_values[i])
         queue_value(directed_values[i], directed_values[i] == 2147483647);
      for (int i = 0; i < N_RANDOM; i++) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            v = $urandom_range(4095);
         end else if (kind < 65) begin
            prod = 1;
            repeat ($urandom_range(1, 10)) begin
               p = small_primes[$urandom_range(11)];
               if (prod * p <= tdf_pkg::MAG_MAX) prod = prod * p;
            end
            v = prod[tdf_pkg::VALUE_W-1:0];
         end else if (kind < 80) begin
            v = $urandom_range(1, 255) << $urandom_range(0, 23);
         end else if (kind < 97) begin
            v = $urandom_range(0, (1 << 20) - 1);
         end else begin
            v = $urandom_range(0, (1 << 24) - 1);
         end
         if ($urandom_range(1)) v = -v;
         queue_value(v, (i % DRAIN_EVERY) == DRAIN_EVERY - 1);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (!timed_out && (request_queue.size() != 0 || req_valid ||
                            expected_factors.size() != 0))
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (!timed_out && mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/tdf_pkg.sv
hdl/trial_division_factorizer_top.sv
tb/tb_trial_division_factorizer_top.sv
